// ===== design/skew_timing_check_monitor_macros.svh =====
// Assertion macros shared by the skew timing check monitor.
// Each macro checks one implication on the rising clock edge and is
// disabled while reset is high. With SYNTHESIS defined they expand to nothing.
`ifndef SKEW_TIMING_CHECK_MONITOR_MACROS_SVH
`define SKEW_TIMING_CHECK_MONITOR_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define STCM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define STCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define STCM_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define STCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/stcm_pkg.sv =====
`default_nettype none

package stcm_pkg;

   localparam int TIME_W  = 48;
   localparam int LIMIT_W = 32;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // Request op codes.
   localparam logic [1:0] OP_REF     = 2'd0;
   localparam logic [1:0] OP_DATA    = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;
   localparam logic [1:0] OP_IGNORED = 2'd3;

   // Check modes as written to the mode register.
   localparam logic [1:0] MODE_SKEW     = 2'd0;
   localparam logic [1:0] MODE_TIMESKEW = 2'd1;
   localparam logic [1:0] MODE_FULLSKEW = 2'd2;

   // Violation kinds.
   localparam logic [1:0] KIND_SKEW     = 2'd0;
   localparam logic [1:0] KIND_TIMESKEW = 2'd1;
   localparam logic [1:0] KIND_FULLSKEW = 2'd2;

   // Register indexes (byte address is four times the index).
   localparam logic [1:0] REG_CHECK_MODE = 2'd0;
   localparam logic [1:0] REG_LIMIT_ONE  = 2'd1;
   localparam logic [1:0] REG_LIMIT_TWO  = 2'd2;
   localparam logic [1:0] REG_CHECKS_OFF = 2'd3;

   typedef struct packed {
      logic [1:0]         check_mode;
      logic [LIMIT_W-1:0] limit_one;
      logic [LIMIT_W-1:0] limit_two;
      logic               checks_off;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [TIME_W-1:0] now;
   } item_type;

   typedef struct packed {
      logic               window_open;
      logic               reference_opened;
      logic [TIME_W-1:0]  stamp_time;
      logic [TIME_W-1:0]  deadline_time;
      logic [LIMIT_W-1:0] armed_limit;
      logic               notifier_bit;
   } state_type;

   typedef struct packed {
      logic [1:0]         violation_kind;
      logic [LIMIT_W-1:0] limit_used;
      logic [TIME_W-1:0]  window_start;
      logic [TIME_W-1:0]  report_time;
      logic               notifier;
   } result_type;

endpackage

`default_nettype wire

// ===== design/stcm_csr.sv =====
`default_nettype none

module stcm_csr
   import stcm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_CHECK_MODE: cfg_in.check_mode = csr_pwdata[1:0];
            REG_LIMIT_ONE:  cfg_in.limit_one  = csr_pwdata[LIMIT_W-1:0];
            REG_LIMIT_TWO:  cfg_in.limit_two  = csr_pwdata[LIMIT_W-1:0];
            REG_CHECKS_OFF: cfg_in.checks_off = csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CHECK_MODE: csr_prdata = {{(CSR_DW-2){1'b0}}, cfg_ff.check_mode};
         REG_LIMIT_ONE:  csr_prdata = cfg_ff.limit_one;
         REG_LIMIT_TWO:  csr_prdata = cfg_ff.limit_two;
         REG_CHECKS_OFF: csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.checks_off};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/stcm_eval.sv =====
`default_nettype none

// Next-state and violation logic for one request against the window state.
module stcm_eval
   import stcm_pkg::*;
(
   input  wire cfg_type   cfg,
   input  wire item_type  item,
   input  wire state_type cur,
   output state_type  nxt,
   output logic       emit,
   output result_type res
);

   logic [1:0]         kind;
   logic               by_ref;
   logic               fire;
   logic               skew_hit;
   logic [LIMIT_W-1:0] open_limit;
   logic [TIME_W:0]    open_sum;
   logic [TIME_W-1:0]  open_deadline;
   logic [TIME_W-1:0]  elapsed;

   always_comb begin
      // A mode of three behaves as fullskew.
      kind          = (cfg.check_mode >= MODE_FULLSKEW) ? KIND_FULLSKEW : cfg.check_mode;
      by_ref        = (item.op == OP_REF);
      open_limit    = by_ref ? cfg.limit_one : cfg.limit_two;
      open_sum      = {1'b0, item.now} + {{(TIME_W+1-LIMIT_W){1'b0}}, open_limit};
      open_deadline = open_sum[TIME_W] ? {TIME_W{1'b1}} : open_sum[TIME_W-1:0];
      elapsed       = item.now - cur.stamp_time;
      fire          = 1'b0;
      skew_hit      = 1'b0;
      nxt           = cur;

      res.violation_kind = kind;
      res.limit_used     = cur.armed_limit;
      res.window_start   = cur.stamp_time;
      res.report_time    = cur.deadline_time;
      res.notifier       = !cur.notifier_bit;

      if (item.op != OP_IGNORED) begin
         // Deadline check of a timer window comes ahead of the event itself.
         if (cur.window_open && (kind != KIND_SKEW)) begin
            fire = (item.op == OP_TICK) ? (item.now >= cur.deadline_time)
                                        : (item.now >  cur.deadline_time);
         end
         if (fire) begin
            nxt.window_open = 1'b0;
         end

         if (item.op != OP_TICK) begin
            if (kind == KIND_FULLSKEW) begin
               if (nxt.window_open && (cur.reference_opened != by_ref)) begin
                  nxt.window_open = 1'b0;
               end else begin
                  nxt.window_open      = 1'b1;
                  nxt.reference_opened = by_ref;
                  nxt.stamp_time       = item.now;
                  nxt.armed_limit      = open_limit;
                  nxt.deadline_time    = open_deadline;
               end
            end else if (by_ref) begin
               nxt.window_open      = 1'b1;
               nxt.reference_opened = 1'b1;
               nxt.stamp_time       = item.now;
               nxt.armed_limit      = open_limit;
               nxt.deadline_time    = open_deadline;
            end else if (kind == KIND_TIMESKEW) begin
               nxt.window_open = 1'b0;
            end else begin
               skew_hit = cur.window_open && (item.now > cur.stamp_time) &&
                          (elapsed > {{(TIME_W-LIMIT_W){1'b0}}, cfg.limit_one});
            end
         end
      end

      if (skew_hit) begin
         res.violation_kind = KIND_SKEW;
         res.limit_used     = cfg.limit_one;
         res.report_time    = item.now;
      end

      emit = (fire || skew_hit) && !cfg.checks_off;
      if (emit) begin
         nxt.notifier_bit = !cur.notifier_bit;
      end
   end

endmodule

`default_nettype wire

// ===== design/skew_timing_check_monitor.sv =====
// Channel    Direction  Payload (low bits first)                          Handshake
// req_       in         tuser: op[1:0]; tdata: now[47:0]                   tvalid/tready
// rsp_       out        tuser: violation_kind[1:0]; tdata: limit_used,     tvalid/tready
//                       window_start, report_time, notifier, zero fill
// csr_       in         APB-style register port, four 32-bit registers     psel/penable
//
// An accepted request sits in the input register until the evaluation stage moves
// on, and any result it produces is then loaded into the result register.
// One request is accepted every cycle as long as the result side drains.
// Reset is synchronous and active high and clears the valid flags, configuration and window state.
// A result waiting on rsp_tready holds the evaluation stage, and the input
// register then takes no new request until the result register frees up.
`default_nettype none

`include "skew_timing_check_monitor_macros.svh"

module skew_timing_check_monitor
   import stcm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   // Request channel.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [47:0]       req_tdata,   // now[47:0]
   input  wire logic [1:0]        req_tuser,   // op[1:0]

   // Result channel.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [135:0]      rsp_tdata,   // limit_used[31:0], window_start[79:32],
                                               // report_time[127:80], notifier[128], zeros
   output logic      [1:0]        rsp_tuser,   // violation_kind[1:0]

   // Configuration port.
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   // Window state after reset: closed, with the reference side as opener.
   localparam state_type STATE_RESET = {2'b01, {(2*TIME_W+LIMIT_W+1){1'b0}}};

   cfg_type    cfg;

   // Input register holding the request under evaluation.
   logic       s1_valid_ff;
   logic       s1_valid_in;
   item_type   s1_item_ff;
   item_type   s1_item_in;

   // Window and notifier state, updated once per evaluated request.
   state_type  state_ff;
   state_type  state_in;
   state_type  state_nxt;

   // Result register.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_result_ff;
   result_type rsp_result_in;

   logic       emit;
   result_type eval_res;
   logic       s1_adv;
   logic       req_fire;

   stcm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   stcm_eval u_eval (
      .cfg  (cfg),
      .item (s1_item_ff),
      .cur  (state_ff),
      .nxt  (state_nxt),
      .emit (emit),
      .res  (eval_res)
   );

   // The evaluation stage moves on when the result register is free or is
   // being taken in this cycle; the input register refills in the same cycle.
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_fire) begin
         s1_valid_in    = 1'b1;
         s1_item_in.op  = req_tuser;
         s1_item_in.now = req_tdata;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in      = s1_adv ? state_nxt : state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (s1_adv) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_result_in = eval_res;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_item_ff    <= s1_item_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.violation_kind;
   assign rsp_tdata  = {7'd0,
                        rsp_result_ff.notifier,
                        rsp_result_ff.report_time,
                        rsp_result_ff.window_start,
                        rsp_result_ff.limit_used};

   // With checks off an evaluated request never produces a result.
   `STCM_ASSERT_NEXT(a_off_no_result, clock, reset, s1_adv && cfg.checks_off, !rsp_tvalid, "result produced while checks are off")

   // The notifier toggles exactly when a result is loaded.
   `STCM_ASSERT_NEXT(a_notifier_toggle, clock, reset, s1_adv && emit, state_ff.notifier_bit == !$past(state_ff.notifier_bit), "notifier did not toggle on a result")

   // A pending result always carries the current notifier value.
   `STCM_ASSERT_SAME(a_notifier_match, clock, reset, rsp_valid_ff, rsp_result_ff.notifier == state_ff.notifier_bit, "result notifier differs from notifier state")

   // A violation is never reported ahead of the window start.
   `STCM_ASSERT_SAME(a_report_order, clock, reset, rsp_valid_ff, rsp_result_ff.report_time >= rsp_result_ff.window_start, "report time earlier than window start")

   // The request side only stalls behind a held evaluation stage.
   `STCM_ASSERT_SAME(a_stall_cause, clock, reset, !req_tready, s1_valid_ff && rsp_valid_ff && !rsp_tready, "request stalled without a held result")

endmodule

`default_nettype wire
